@@ src/slic_pkg.sv @@
`default_nettype none

package slic_pkg;

    // Store geometry. Addresses are {row, column}.
    localparam int MAX_COLS     = 512;
    localparam int MAX_ROWS     = 512;
    localparam int MAX_CLUSTERS = 4096;
    localparam int COL_W        = $clog2(MAX_COLS);
    localparam int ROW_W        = $clog2(MAX_ROWS);
    localparam int ADDR_W       = COL_W + ROW_W;
    localparam int DEPTH        = MAX_COLS * MAX_ROWS;

    localparam int LABEL_W = 12;
    localparam int DIST_W  = 34;
    localparam int PIX_W   = 24;
    localparam int DL_W    = LABEL_W + DIST_W;
    localparam int CNT_W   = 19;
    localparam int SUM_W   = 27;
    localparam int MUL_W   = 17;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_APPLY  = 3'd2,
        OP_UPDATE = 3'd3,
        OP_READ   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        REG_COLS   = 3'd0,
        REG_ROWS   = 3'd1,
        REG_SRCH_X = 3'd2,
        REG_SRCH_Y = 3'd3,
        REG_WEIGHT = 3'd4,
        REG_MODE   = 3'd5
    } cfg_index_t;

    // Order in which the averages go through the divider.
    typedef enum logic [2:0] {
        DIV_X = 3'd0,
        DIV_Y = 3'd1,
        DIV_R = 3'd2,
        DIV_G = 3'd3,
        DIV_B = 3'd4
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_RD_OUT,
        ST_A_DX,
        ST_A_DY,
        ST_A_W,
        ST_A_R,
        ST_A_G,
        ST_A_B,
        ST_A_CMP,
        ST_U_WAIT,
        ST_U_ACC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_U_OUT
    } state_t;

endpackage

`default_nettype wire

@@ src/slic_ram.sv @@
`default_nettype none

module slic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/slic_cluster_assign_update_top.sv @@
`default_nettype none

// SLIC cluster assignment and update engine. The block keeps a pixel store
// and, for every pixel, a best distance and a cluster label, all addressed
// as {row, column}. Items arrive on the slave stream one beat at a time and
// the block takes no new beat until the current one is finished. A clear
// beat, and the startup after reset, sweep the distance/label memory one
// entry per cycle, during which tready stays low (configuration writes are
// still taken). An apply beat walks the clipped search window and passes
// each pixel through ST_A_DX, ST_A_DY, ST_A_W, ST_A_R, ST_A_G, ST_A_B and
// ST_A_CMP, using one shared 17x17 multiplier that forms the spatial and
// color squares in turn. An update beat passes each window pixel through
// ST_U_WAIT and ST_U_ACC, then runs a one-bit-per-cycle restoring divider
// five times for the averages, unless no pixel carried the label. Update
// and read each return one result beat on the master stream; a finished
// result waits in an output register, and the engine only stalls if a
// second result is ready before the first one was taken.
module slic_cluster_assign_update_top
    import slic_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Configuration write port.
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata,
    // Input stream. tdata from bit 0: opcode[2:0], pos_x[11:3], pos_y[20:12],
    // cluster[32:21], red[40:33], green[48:41], blue[56:49], zero fill.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,
    // Result stream. tdata from bit 0: label[11:0], best_distance[45:12],
    // new_x[54:46], new_y[63:55], new_red[71:64], new_green[79:72],
    // new_blue[87:80], center_valid[88], member_count[107:89], zero fill.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [9:0]  img_cols_reg, img_rows_reg;
    logic [7:0]  search_x_reg, search_y_reg;
    logic [15:0] weight_reg;
    logic        color_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_cols_reg   <= 10'd512;
            img_rows_reg   <= 10'd512;
            search_x_reg   <= 8'd16;
            search_y_reg   <= 8'd16;
            weight_reg     <= 16'd10;
            color_mode_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_COLS:   img_cols_reg   <= cfg_wdata[9:0];
                REG_ROWS:   img_rows_reg   <= cfg_wdata[9:0];
                REG_SRCH_X: search_x_reg   <= cfg_wdata[7:0];
                REG_SRCH_Y: search_y_reg   <= cfg_wdata[7:0];
                REG_WEIGHT: weight_reg     <= cfg_wdata;
                REG_MODE:   color_mode_reg <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // Last valid column and row: zero acts as one, large values saturate.
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    always_comb
    begin
        if (img_cols_reg == 10'd0)
            col_last = '0;
        else if (img_cols_reg > 10'(MAX_COLS))
            col_last = COL_W'(MAX_COLS - 1);
        else
            col_last = COL_W'(img_cols_reg - 10'd1);
        if (img_rows_reg == 10'd0)
            row_last = '0;
        else if (img_rows_reg > 10'(MAX_ROWS))
            row_last = ROW_W'(MAX_ROWS - 1);
        else
            row_last = ROW_W'(img_rows_reg - 10'd1);
    end

    // ------------------------------------------------------------------
    // Input fields and the clipped window of the incoming beat.
    // ------------------------------------------------------------------
    logic [2:0]         in_op;
    logic [COL_W-1:0]   in_x;
    logic [ROW_W-1:0]   in_y;
    logic [LABEL_W-1:0] in_k;
    logic [7:0]         in_r, in_g, in_b;

    assign in_op = s_tdata[2:0];
    assign in_x  = s_tdata[11:3];
    assign in_y  = s_tdata[20:12];
    assign in_k  = s_tdata[32:21];
    assign in_r  = s_tdata[40:33];
    assign in_g  = s_tdata[48:41];
    assign in_b  = s_tdata[56:49];

    logic [COL_W:0]   x_sum;
    logic [ROW_W:0]   y_sum;
    logic [COL_W-1:0] win_xlo, win_xhi;
    logic [ROW_W-1:0] win_ylo, win_yhi;
    logic             win_empty;
    logic             in_inside;

    always_comb
    begin
        win_xlo = (in_x >= COL_W'(search_x_reg)) ? in_x - COL_W'(search_x_reg) : '0;
        win_ylo = (in_y >= ROW_W'(search_y_reg)) ? in_y - ROW_W'(search_y_reg) : '0;
        x_sum   = (COL_W+1)'(in_x) + (COL_W+1)'(search_x_reg);
        y_sum   = (ROW_W+1)'(in_y) + (ROW_W+1)'(search_y_reg);
        win_xhi = (x_sum > (COL_W+1)'(col_last)) ? col_last : x_sum[COL_W-1:0];
        win_yhi = (y_sum > (ROW_W+1)'(row_last)) ? row_last : y_sum[ROW_W-1:0];
        win_empty = (win_xlo > win_xhi) || (win_ylo > win_yhi);
        in_inside = (in_x <= col_last) && (in_y <= row_last);
    end

    // ------------------------------------------------------------------
    // State and working registers.
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [COL_W-1:0]   x_reg, xlo_reg, xhi_reg, cx_reg;
    logic [ROW_W-1:0]   y_reg, yhi_reg, cy_reg;
    logic [LABEL_W-1:0] k_reg;
    logic [7:0]         cr_reg, cg_reg, cb_reg;
    logic               inside_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;

    logic [2*MUL_W-1:0] prod_reg;
    logic [DIST_W-1:0]  acc_reg;

    logic [SUM_W-1:0]   sx_reg, sy_reg, sr_reg, sg_reg, sb_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [SUM_W-1:0]   dvd_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [4:0]         bit_reg;
    div_sel_t           sel_reg;
    logic [COL_W-1:0]   qx_reg;
    logic [ROW_W-1:0]   qy_reg;
    logic [7:0]         qr_reg, qg_reg, qb_reg;

    logic               m_valid_reg;
    logic [111:0]       m_data_reg;

    // ------------------------------------------------------------------
    // Memories.
    // ------------------------------------------------------------------
    logic               pix_we;
    logic [PIX_W-1:0]   pix_rdata;
    logic               dl_we;
    logic [ADDR_W-1:0]  dl_waddr;
    logic [DL_W-1:0]    dl_wdata;
    logic [DL_W-1:0]    dl_rdata;
    logic [ADDR_W-1:0]  rd_addr;

    assign rd_addr = {y_reg, x_reg};

    slic_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr ({in_y, in_x}),
        .wdata ({in_b, in_g, in_r}),
        .raddr (rd_addr),
        .rdata (pix_rdata)
    );

    slic_ram #(.WIDTH(DL_W), .DEPTH(DEPTH)) u_dl_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (rd_addr),
        .rdata (dl_rdata)
    );

    logic [LABEL_W-1:0] st_label;
    logic [DIST_W-1:0]  st_dist;
    logic [7:0]         p_r, p_g, p_b;

    assign st_dist  = dl_rdata[DIST_W-1:0];
    assign st_label = dl_rdata[DL_W-1:DIST_W];
    assign p_r      = pix_rdata[7:0];
    assign p_g      = pix_rdata[15:8];
    assign p_b      = pix_rdata[23:16];

    // ------------------------------------------------------------------
    // Shared datapath helpers.
    // ------------------------------------------------------------------
    logic [7:0] dx, dy, dr, dg, db;
    logic       at_row_end, at_last;
    logic       out_free;

    assign dx = 8'((x_reg > cx_reg) ? x_reg - cx_reg : cx_reg - x_reg);
    assign dy = 8'((y_reg > cy_reg) ? y_reg - cy_reg : cy_reg - y_reg);
    assign dr = (p_r > cr_reg) ? p_r - cr_reg : cr_reg - p_r;
    assign dg = (p_g > cg_reg) ? p_g - cg_reg : cg_reg - p_g;
    assign db = (p_b > cb_reg) ? p_b - cb_reg : cb_reg - p_b;

    assign at_row_end = (x_reg == xhi_reg);
    assign at_last    = at_row_end && (y_reg == yhi_reg);
    assign out_free   = !m_valid_reg || m_tready;

    // Final distance of the current pixel; the blue square is in prod_reg.
    logic [DIST_W-1:0] dist_new;
    logic              closer;

    assign dist_new = acc_reg + (color_mode_reg ? prod_reg : '0);
    assign closer   = dist_new < st_dist;

    // Member test for the update walk.
    logic hit;
    assign hit = (st_label == k_reg);

    // One restoring divider step.
    logic [CNT_W:0]   rem_shift;
    logic             q_bit;
    logic [CNT_W-1:0] rem_step;
    logic [SUM_W-1:0] quo_step;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
        q_bit     = rem_shift >= {1'b0, cnt_reg};
        rem_step  = q_bit ? CNT_W'(rem_shift - {1'b0, cnt_reg}) : CNT_W'(rem_shift);
        quo_step  = {dvd_reg[SUM_W-2:0], q_bit};
    end

    logic [SUM_W-1:0] div_src;

    always_comb
    begin
        case (sel_reg)
            DIV_X:   div_src = sx_reg;
            DIV_Y:   div_src = sy_reg;
            DIV_R:   div_src = sr_reg;
            DIV_G:   div_src = sg_reg;
            DIV_B:   div_src = sb_reg;
            default: div_src = '0;
        endcase
    end

    // Center fields of an update result, from new_x up to center_valid.
    logic [42:0] upd_fields;

    always_comb
    begin
        if (cnt_reg == '0)
            // No members: the incoming center is echoed unchanged.
            upd_fields = {1'b0, cb_reg, cg_reg, cr_reg, cy_reg, cx_reg};
        else if (color_mode_reg)
            upd_fields = {1'b1, qb_reg, qg_reg, qr_reg, qy_reg, qx_reg};
        else
            upd_fields = {1'b1, 8'd0, 8'd0, qr_reg, qy_reg, qx_reg};
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (&clr_cnt_reg)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid)
                begin
                    case (in_op)
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_APPLY:  state_next = win_empty ? ST_IDLE : ST_A_DX;
                        OP_UPDATE: state_next = win_empty ? ST_U_OUT : ST_U_WAIT;
                        OP_READ:   state_next = ST_RD_WAIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            ST_RD_WAIT: state_next = ST_RD_OUT;
            ST_RD_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            ST_A_DX:  state_next = ST_A_DY;
            ST_A_DY:  state_next = ST_A_W;
            ST_A_W:   state_next = ST_A_R;
            ST_A_R:   state_next = ST_A_G;
            ST_A_G:   state_next = ST_A_B;
            ST_A_B:   state_next = ST_A_CMP;
            ST_A_CMP: state_next = at_last ? ST_IDLE : ST_A_DX;
            ST_U_WAIT: state_next = ST_U_ACC;
            ST_U_ACC:  state_next = at_last ? ST_DIV_LOAD : ST_U_WAIT;
            ST_DIV_LOAD:
                state_next = (cnt_reg == '0) ? ST_U_OUT : ST_DIV;
            ST_DIV:
                if (bit_reg == 5'(SUM_W - 1))
                    state_next = (sel_reg == DIV_B) ? ST_U_OUT : ST_DIV_LOAD;
            ST_U_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs: handshake, memory writes and multiplier operands.
    // ------------------------------------------------------------------
    logic [MUL_W-1:0] mul_a, mul_b;

    always_comb
    begin
        s_tready = 1'b0;
        pix_we   = 1'b0;
        dl_we    = 1'b0;
        dl_waddr = rd_addr;
        dl_wdata = {k_reg, dist_new};
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                dl_we    = 1'b1;
                dl_waddr = clr_cnt_reg;
                dl_wdata = {{LABEL_W{1'b0}}, DIST_MAX};
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                pix_we   = s_tvalid && (in_op == OP_WRITE) && in_inside;
            end
            ST_A_DX:
            begin
                mul_a = MUL_W'(dx);
                mul_b = MUL_W'(dx);
            end
            ST_A_DY:
            begin
                mul_a = MUL_W'(dy);
                mul_b = MUL_W'(dy);
            end
            ST_A_W:
            begin
                mul_a = MUL_W'(weight_reg);
                mul_b = acc_reg[MUL_W-1:0] + prod_reg[MUL_W-1:0];
            end
            ST_A_R:
            begin
                mul_a = MUL_W'(dr);
                mul_b = MUL_W'(dr);
            end
            ST_A_G:
            begin
                mul_a = MUL_W'(dg);
                mul_b = MUL_W'(dg);
            end
            ST_A_B:
            begin
                mul_a = MUL_W'(db);
                mul_b = MUL_W'(db);
            end
            ST_A_CMP:
                dl_we = closer;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            else
                clr_cnt_reg <= '0;
            if ((state_reg == ST_RD_OUT || state_reg == ST_U_OUT) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

        case (state_reg)
            ST_IDLE:
            begin
                cx_reg     <= in_x;
                cy_reg     <= in_y;
                k_reg      <= in_k;
                cr_reg     <= in_r;
                cg_reg     <= in_g;
                cb_reg     <= in_b;
                inside_reg <= in_inside;
                xlo_reg    <= win_xlo;
                xhi_reg    <= win_xhi;
                yhi_reg    <= win_yhi;
                sx_reg     <= '0;
                sy_reg     <= '0;
                sr_reg     <= '0;
                sg_reg     <= '0;
                sb_reg     <= '0;
                cnt_reg    <= '0;
                sel_reg    <= DIV_X;
                // A read addresses the pixel itself, the walks start at the corner.
                if (in_op == OP_READ)
                begin
                    x_reg <= in_x;
                    y_reg <= in_y;
                end
                else
                begin
                    x_reg <= win_xlo;
                    y_reg <= win_ylo;
                end
            end
            ST_A_DY:
                acc_reg <= DIST_W'(prod_reg);
            ST_A_R:
                acc_reg <= DIST_W'(prod_reg);
            ST_A_G:
                acc_reg <= acc_reg + DIST_W'(prod_reg);
            ST_A_B:
                acc_reg <= acc_reg + (color_mode_reg ? DIST_W'(prod_reg) : '0);
            ST_A_CMP, ST_U_ACC:
            begin
                if (state_reg == ST_U_ACC && hit)
                begin
                    sx_reg  <= sx_reg + SUM_W'(x_reg);
                    sy_reg  <= sy_reg + SUM_W'(y_reg);
                    sr_reg  <= sr_reg + SUM_W'(p_r);
                    sg_reg  <= sg_reg + SUM_W'(p_g);
                    sb_reg  <= sb_reg + SUM_W'(p_b);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (at_row_end)
                begin
                    x_reg <= xlo_reg;
                    if (!at_last)
                        y_reg <= y_reg + 1'b1;
                end
                else
                begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            ST_DIV_LOAD:
            begin
                dvd_reg <= div_src;
                rem_reg <= '0;
                bit_reg <= '0;
            end
            ST_DIV:
            begin
                dvd_reg <= quo_step;
                rem_reg <= rem_step;
                bit_reg <= bit_reg + 1'b1;
                if (bit_reg == 5'(SUM_W - 1))
                begin
                    case (sel_reg)
                        DIV_X:   qx_reg <= quo_step[COL_W-1:0];
                        DIV_Y:   qy_reg <= quo_step[ROW_W-1:0];
                        DIV_R:   qr_reg <= quo_step[7:0];
                        DIV_G:   qg_reg <= quo_step[7:0];
                        DIV_B:   qb_reg <= quo_step[7:0];
                        default: ;
                    endcase
                    sel_reg <= div_sel_t'(sel_reg + 3'd1);
                end
            end
            default: ;
        endcase

        // Result register, loaded once the previous beat has gone.
        if (state_reg == ST_RD_OUT && out_free)
        begin
            m_data_reg <= {66'd0, (inside_reg ? {st_dist, st_label} : 46'd0)};
        end
        else if (state_reg == ST_U_OUT && out_free)
        begin
            m_data_reg <= {4'd0, cnt_reg, upd_fields, 46'd0};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The distance/label memory is only written by the sweep or by a win.
    assert property (@(posedge clk) disable iff (!rst_n)
        dl_we |-> (state_reg == ST_CLEAR || state_reg == ST_A_CMP))
        else $error("distance memory written outside clear or compare");

    // A relabel always lowers the stored distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_CMP && dl_we) |-> (dist_new < st_dist))
        else $error("relabel without a smaller distance");

    // The walk stays inside the clipped window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_DX || state_reg == ST_U_WAIT)
            |-> (x_reg >= xlo_reg && x_reg <= xhi_reg && y_reg <= yhi_reg))
        else $error("window walk left the window");

    // The divider remainder stays below the member count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < cnt_reg))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire
